### rtl/core/mwh_pkg.sv
// ----------------------------------------------------------------------------
// mwh_pkg
// Shared types, constants and the microcode program of the word hash.
// ----------------------------------------------------------------------------
package mwh_pkg;

  localparam logic [31:0] MIX_MUL   = 32'h5bd1_e995;
  localparam int          MIX_SHIFT = 24;
  localparam logic [31:0] START_KEY = 32'h9747_b28c;
  localparam int          AV_SHIFT1 = 13;
  localparam int          AV_SHIFT2 = 15;

  localparam int          STEP_W    = 3;
  localparam logic [2:0]  BYTES_FULL = 3'd4;

  typedef logic [STEP_W-1:0] step_t;

  // Program entry points and step addresses
  localparam step_t STEP_KEY_MUL  = 3'd0;
  localparam step_t STEP_KEY_MIX  = 3'd1;
  localparam step_t STEP_HASH_MIX = 3'd2;
  localparam step_t STEP_TAIL     = 3'd3;
  localparam step_t STEP_AVAL     = 3'd4;
  localparam step_t STEP_OUT      = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_KEY_MUL,   // k <= word * m
    OP_KEY_MIX,   // k <= (k ^ k>>24) * m
    OP_HASH_MIX,  // h <= (h * m) ^ k
    OP_TAIL,      // h <= (h ^ tail bytes) * m
    OP_AVAL,      // t <= (h ^ h>>13) * m
    OP_OUT        // result <= t ^ t>>15
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,     // advance to the following step
    JMP_IF_LAST,  // go to target on the last word, else finish
    JMP_DONE      // finish the word
  } jmp_t;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    step_t tgt;
  } ctrl_t;

  function automatic ctrl_t prog_rom(input step_t pc);
    ctrl_t cw;
    case (pc)
      STEP_KEY_MUL:  cw = '{op: OP_KEY_MUL,  jmp: JMP_NEXT,    tgt: STEP_KEY_MIX};
      STEP_KEY_MIX:  cw = '{op: OP_KEY_MIX,  jmp: JMP_NEXT,    tgt: STEP_HASH_MIX};
      STEP_HASH_MIX: cw = '{op: OP_HASH_MIX, jmp: JMP_IF_LAST, tgt: STEP_AVAL};
      STEP_TAIL:     cw = '{op: OP_TAIL,     jmp: JMP_IF_LAST, tgt: STEP_AVAL};
      STEP_AVAL:     cw = '{op: OP_AVAL,     jmp: JMP_NEXT,    tgt: STEP_OUT};
      STEP_OUT:      cw = '{op: OP_OUT,      jmp: JMP_DONE,    tgt: STEP_KEY_MUL};
      default:       cw = '{op: OP_NOP,      jmp: JMP_DONE,    tgt: STEP_KEY_MUL};
    endcase
    return cw;
  endfunction

  // Keep only the valid low bytes of a partial word
  function automatic logic [31:0] tail_bytes(input logic [31:0] w, input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return w & m;
  endfunction

endpackage

### rtl/core/mwh_if.sv
// ----------------------------------------------------------------------------
// mwh_in_if / mwh_out_if
// Valid/ready channels for key words and finished hashes.
// ----------------------------------------------------------------------------
interface mwh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] seed;
  logic [30:0] total_length;

  modport source (output valid, word, byte_count, first, last, seed, total_length,
                  input ready);
  modport sink   (input valid, word, byte_count, first, last, seed, total_length,
                  output ready);
endinterface

interface mwh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;

  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

### rtl/core/murmur2_word_hash_top.sv
// ----------------------------------------------------------------------------
// murmur2_word_hash_top
// 32-bit MurmurHash2 over little-endian key words, run by a microcoded
// sequencer around one constant multiplier.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                             | flow
//  --------+-----+-----------------------------------------------------+------------
//  key     | in  | word, byte_count, first, last, seed, total_length   | valid/ready
//  result  | out | hash                                                | valid/ready
//
//  A full word holds the key channel for the accept and 3 multiply steps, a
//  tail word for the accept and the tail step, a word with no bytes for the
//  accept alone; the last word of a key adds the avalanche and result load.
//  Multiply steps share one m-multiplier; steps per word set the word rate.
//  Reset clears the running hash to zero and empties the sequencer.
//  A waiting result stalls only the result-load step; a new word is taken as
//  soon as the sequencer is free, even while the previous hash waits.

module murmur2_word_hash_top (
  input  logic      clk,
  input  logic      rst,
  mwh_in_if.sink    key,
  mwh_out_if.source result
);

  // Sequencer
  logic                busy;
  mwh_pkg::step_t      pc;
  mwh_pkg::ctrl_t      cw;
  logic                step_go;

  // Datapath
  logic [31:0] h;          // running hash
  logic [31:0] k;          // word being mixed
  logic [31:0] t;          // avalanche intermediate
  logic [31:0] word_q;
  logic [2:0]  count_q;
  logic        last_q;
  logic [31:0] out_hash;
  logic        out_valid;

  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] h_start;
  logic        accept;

  assign key.ready    = !busy;
  assign accept       = key.valid && key.ready;
  assign result.valid = out_valid;
  assign result.hash  = out_hash;

  assign cw = mwh_pkg::prog_rom(pc);

  // Hold the result-load step while the output register is full and not being taken
  assign step_go = busy && !(cw.op == mwh_pkg::OP_OUT && out_valid && !result.ready);

  assign h_start = key.seed ^ {1'b0, key.total_length} ^ mwh_pkg::START_KEY;

  // Operand select for the shared multiplier
  always_comb begin
    case (cw.op)
      mwh_pkg::OP_KEY_MUL:  mul_a = word_q;
      mwh_pkg::OP_KEY_MIX:  mul_a = k ^ (k >> mwh_pkg::MIX_SHIFT);
      mwh_pkg::OP_HASH_MIX: mul_a = h;
      mwh_pkg::OP_TAIL:     mul_a = h ^ mwh_pkg::tail_bytes(word_q, count_q);
      mwh_pkg::OP_AVAL:     mul_a = h ^ (h >> mwh_pkg::AV_SHIFT1);
      default:              mul_a = h;
    endcase
  end

  assign prod = mul_a * mwh_pkg::MIX_MUL;

  // Step counter and dispatch
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= mwh_pkg::STEP_KEY_MUL;
    end else if (accept) begin
      // Dispatch on the byte count; an empty non-last word needs no steps
      if (key.byte_count >= mwh_pkg::BYTES_FULL) begin
        busy <= 1'b1;
        pc   <= mwh_pkg::STEP_KEY_MUL;
      end else if (key.byte_count != 3'd0) begin
        busy <= 1'b1;
        pc   <= mwh_pkg::STEP_TAIL;
      end else begin
        busy <= key.last;
        pc   <= mwh_pkg::STEP_AVAL;
      end
    end else if (step_go) begin
      case (cw.jmp)
        mwh_pkg::JMP_NEXT: begin
          pc <= cw.tgt;
        end
        mwh_pkg::JMP_IF_LAST: begin
          pc   <= cw.tgt;
          busy <= last_q;
        end
        default: begin
          busy <= 1'b0;
        end
      endcase
    end
  end

  // Running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else if (accept) begin
      if (key.first) begin
        h <= h_start;
      end
    end else if (step_go) begin
      case (cw.op)
        mwh_pkg::OP_HASH_MIX: h <= prod ^ k;
        mwh_pkg::OP_TAIL:     h <= prod;
        default:              h <= h;
      endcase
    end
  end

  // Word capture and mixing registers
  always_ff @(posedge clk) begin
    if (accept) begin
      word_q  <= key.word;
      count_q <= key.byte_count;
      last_q  <= key.last;
    end
    if (step_go && (cw.op == mwh_pkg::OP_KEY_MUL || cw.op == mwh_pkg::OP_KEY_MIX)) begin
      k <= prod;
    end
    if (step_go && cw.op == mwh_pkg::OP_AVAL) begin
      t <= prod;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && cw.op == mwh_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && cw.op == mwh_pkg::OP_OUT) begin
      out_hash <= t ^ (t >> mwh_pkg::AV_SHIFT2);
    end
  end

`ifndef SYNTHESIS
  // A fresh result only follows an executed result-load step
  a_result_from_out_step: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !$past(result.valid)) |-> $past(step_go && cw.op == mwh_pkg::OP_OUT))
    else $error("result raised without result-load step");

  // A full word always starts the program at the key multiply
  a_full_word_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && key.byte_count >= mwh_pkg::BYTES_FULL) |=>
      (busy && pc == mwh_pkg::STEP_KEY_MUL))
    else $error("full word did not enter at key multiply");

  // The sequencer never runs off the end of the program
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc <= mwh_pkg::STEP_OUT))
    else $error("step counter beyond program");
`endif

endmodule

### test/tb_murmur2_word_hash_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_murmur2_word_hash_top
// Self-checking bench for the MurmurHash2 word hash.
// Drives key words over the valid/ready key channel with random gaps and
// predicts every finished hash in the bench. It stalls the result channel at
// random and compares each hash, in order, with the prediction.
// ----------------------------------------------------------------------------
module tb_murmur2_word_hash_top;

  // Hash constants, kept local so the prediction does not lean on the RTL
  localparam logic [31:0] HASH_MUL   = 32'h5bd1_e995;
  localparam logic [31:0] START_MIX  = 32'h9747_b28c;
  localparam int          KEY_SHIFT  = 24;
  localparam int          FIN_SHIFT1 = 13;
  localparam int          FIN_SHIFT2 = 15;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  // Drain allowance once the last hash is in: full word plus avalanche
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  byte_count;
    logic        first;
    logic        last;
    logic [31:0] seed;
    logic [30:0] total_length;
  } key_word_t;

  logic clk;
  logic rst;

  mwh_in_if  key_if ();
  mwh_out_if hash_if ();

  murmur2_word_hash_top uut (
    .clk    (clk),
    .rst    (rst),
    .key    (key_if),
    .result (hash_if)
  );

  // Bench copy of the running hash and the hashes still owed by the block
  logic [31:0] running_hash_model;
  logic [31:0] pending_hashes[$];

  int words_sent;
  int keys_closed;
  int hashes_checked;
  int mismatches;
  bit no_idle;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hold every input at a known value from time zero
  initial begin
    key_if.valid        <= 1'b0;
    key_if.word         <= '0;
    key_if.byte_count   <= '0;
    key_if.first        <= 1'b0;
    key_if.last         <= 1'b0;
    key_if.seed         <= '0;
    key_if.total_length <= '0;
    hash_if.ready       <= 1'b0;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the bench's running hash by one accepted word, and queue the
  // finished hash when the word closes a key.
  function automatic void predict_key_word(input key_word_t kw);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] tail;
    h = running_hash_model;
    // the length field is trusted as is, only the start value sees it
    if (kw.first)
      h = kw.seed ^ {1'b0, kw.total_length} ^ START_MIX;
    if (kw.byte_count >= FULL_BYTES) begin
      // counts of five to seven behave as a full word
      k = kw.word * HASH_MUL;
      k = k ^ (k >> KEY_SHIFT);
      k = k * HASH_MUL;
      h = (h * HASH_MUL) ^ k;
    end else if (kw.byte_count != 3'd0) begin
      // a short word is folded the same way wherever it falls in the key
      case (kw.byte_count)
        3'd1:    tail = {24'h0, kw.word[7:0]};
        3'd2:    tail = {16'h0, kw.word[15:0]};
        default: tail = {8'h0, kw.word[23:0]};
      endcase
      h = (h ^ tail) * HASH_MUL;
    end
    // unfinished value carries on past the last word
    running_hash_model = h;
    if (kw.last) begin
      h = h ^ (h >> FIN_SHIFT1);
      h = h * HASH_MUL;
      h = h ^ (h >> FIN_SHIFT2);
      pending_hashes.push_back(h);
      keys_closed++;
    end
  endfunction

  function automatic key_word_t make_word(input logic [31:0] w, input logic [2:0] n,
                                          input logic f, input logic l,
                                          input logic [31:0] s, input logic [30:0] len);
    key_word_t kw;
    kw.word         = w;
    kw.byte_count   = n;
    kw.first        = f;
    kw.last         = l;
    kw.seed         = s;
    kw.total_length = len;
    return kw;
  endfunction

  // Send one word: idle for a random gap, then hold valid until the block
  // takes it. Valid is left high on return; the caller either sends the next
  // word in the same step or drops valid with release_key_channel.
  task automatic drive_word(input key_word_t kw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_if.valid        <= 1'b1;
    key_if.word         <= kw.word;
    key_if.byte_count   <= kw.byte_count;
    key_if.first        <= kw.first;
    key_if.last         <= kw.last;
    key_if.seed         <= kw.seed;
    key_if.total_length <= kw.total_length;
    do @(posedge clk); while (!key_if.ready);
    predict_key_word(kw);
    words_sent++;
  endtask

  task automatic release_key_channel();
    key_if.valid <= 1'b0;
  endtask

  // Result side: hold ready high for a while, then at random stall for a random gap
  initial begin
    @(posedge clk);
    forever begin
      hash_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        hash_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // Compare each accepted hash with the oldest prediction
  always @(posedge clk) begin
    if (!rst && hash_if.valid && hash_if.ready) begin
      if (pending_hashes.size() == 0) begin
        $error("hash: none expected, actual %08h", hash_if.hash);
        mismatches++;
      end else begin
        logic [31:0] want;
        want = pending_hashes.pop_front();
        if (hash_if.hash !== want) begin
          $error("hash: expected %08h, actual %08h", want, hash_if.hash);
          mismatches++;
        end
        hashes_checked++;
      end
    end
  end

  // Hand-picked words: field extremes and every corner of the word handling
  task automatic test_directed();
    // no first word since reset: hashing starts from zero
    drive_word(make_word($urandom, 3'd4, 1'b0, 1'b1, $urandom, 31'($urandom)));
    // empty key, all-zero seed and length
    drive_word(make_word(32'h0, 3'd0, 1'b1, 1'b1, 32'h0, 31'h0));
    // one full word at the top of every field
    drive_word(make_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'hffff_ffff, 31'h7fff_ffff));
    // carry on from the unfinished hash after a closed key; seed is ignored
    drive_word(make_word(32'h1234_5678, 3'd2, 1'b0, 1'b1, 32'hffff_ffff, 31'h7fff_ffff));
    // full, oversized count, three-byte tail with junk in the top byte
    drive_word(make_word(32'h0403_0201, 3'd4, 1'b1, 1'b0, 32'h0bad_5eed, 31'd11));
    drive_word(make_word(32'h0807_0605, 3'd7, 1'b0, 1'b0, 32'h0, 31'h0));
    drive_word(make_word(32'hff0b_0a09, 3'd3, 1'b0, 1'b1, 32'h0, 31'h0));
    // oversized first word, empty word mid-key, one-byte tail
    drive_word(make_word(32'hdead_beef, 3'd5, 1'b1, 1'b0, 32'h8000_0001, 31'd5));
    drive_word(make_word(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0, 31'h0));
    drive_word(make_word(32'hffff_ffff, 3'd1, 1'b0, 1'b1, 32'h0, 31'h0));
    // short word before the end, and a length that does not match
    drive_word(make_word(32'hcafe_f00d, 3'd2, 1'b1, 1'b0, 32'h5555_aaaa, 31'd1000));
    drive_word(make_word(32'h0f1e_2d3c, 3'd6, 1'b0, 1'b0, 32'h0, 31'h0));
    drive_word(make_word(32'ha5a5_a5a5, 3'd2, 1'b0, 1'b1, 32'h0, 31'h0));
    // zero word, then an empty closing word
    drive_word(make_word(32'h0, 3'd4, 1'b1, 1'b0, 32'h0, 31'h0));
    drive_word(make_word(32'hffff_ffff, 3'd0, 1'b0, 1'b1, 32'hffff_ffff, 31'h7fff_ffff));
    // single-word keys with one and three bytes
    drive_word(make_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'haaaa_5555, 31'h2aaa_aaaa));
    drive_word(make_word(32'h00ab_cdef, 3'd3, 1'b1, 1'b1, 32'h1357_9bdf, 31'h5555_5555));
    // key abandoned without a last word, then restarted
    drive_word(make_word(32'h7777_7777, 3'd4, 1'b1, 1'b0, 32'h2468_ace0, 31'd8));
    drive_word(make_word(32'h8888_8888, 3'd4, 1'b1, 1'b1, 32'h1111_1111, 31'd4));
  endtask

  // Well-formed keys of random content, mostly short, a few long
  task automatic test_random_keys(input int word_budget);
    int          sent;
    int          nbytes;
    int          nwords;
    int          rem;
    int          r;
    logic [31:0] key_seed;
    logic [30:0] key_len;
    key_word_t   kw;
    sent = 0;
    while (sent < word_budget) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        nbytes = $urandom_range(0, 16);
      else if (r < 95)
        nbytes = $urandom_range(17, 48);
      else
        nbytes = $urandom_range(49, 128);
      key_seed = $urandom;
      // now and then a length field that has nothing to do with the key
      key_len = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'(nbytes);
      nwords = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
      for (int i = 0; i < nwords; i++) begin
        rem = nbytes - 4 * i;
        kw.word  = $urandom;
        kw.first = (i == 0);
        kw.last  = (i == nwords - 1);
        if (rem >= 4)
          kw.byte_count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) : FULL_BYTES;
        else
          kw.byte_count = 3'(rem);
        // seed and length only matter on the first word; scramble them elsewhere
        kw.seed         = (i == 0) ? key_seed : $urandom;
        kw.total_length = (i == 0) ? key_len : 31'($urandom);
        drive_word(kw);
        sent++;
      end
    end
  endtask

  // Malformed traffic: random flags and counts, keys cut short or never opened
  task automatic test_random_noise(input int word_budget);
    key_word_t kw;
    for (int i = 0; i < word_budget; i++) begin
      kw.word         = $urandom;
      kw.byte_count   = 3'($urandom_range(0, 7));
      kw.first        = ($urandom_range(0, 3) == 0);
      kw.last         = ($urandom_range(0, 3) == 0);
      kw.seed         = $urandom;
      kw.total_length = 31'($urandom);
      drive_word(kw);
    end
  endtask

  // Back-to-back keys with no gaps and ready held high
  task automatic test_back_to_back(input int word_budget);
    no_idle = 1'b1;
    test_random_keys(word_budget);
    no_idle = 1'b0;
  endtask

  initial begin
    running_hash_model = '0;
    words_sent     = 0;
    keys_closed    = 0;
    hashes_checked = 0;
    mismatches     = 0;
    no_idle        = 1'b0;

    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_keys(780);
    test_random_noise(150);
    test_back_to_back(120);
    release_key_channel();

    // Wait for every owed hash, then give the block time to settle
    while (pending_hashes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Drove %0d key words closing %0d keys: directed corners, random keys,",
             words_sent, keys_closed);
    $display("malformed words and back-to-back traffic; %0d hashes compared.",
             hashes_checked);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Guard against a hang; well above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
